@@ src/smis_pkg.sv @@
// Shared types, constants and index helpers for the sweep-operator matrix inverter.
package smis_pkg;

	localparam int MAX_ORDER   = 8;
	localparam int STORE_DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
	localparam int IDX_W       = $clog2(STORE_DEPTH);

	localparam logic [63:0] NEG_ONE      = 64'hBFF0_0000_0000_0000;
	localparam logic [63:0] DEFAULT_NAN  = 64'hFFF8_0000_0000_0000;
	localparam logic [63:0] DIV_ZERO_NAN = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SUB
	} fpu_op_t;

	typedef struct packed {
		logic    start;
		fpu_op_t op;
	} fpu_req_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_NORM,
		F_MUL,
		F_DIV,
		F_FIN,
		F_ALIGN,
		F_ADD,
		F_LNORM,
		F_DENORM,
		F_ROUND,
		F_DONE
	} fpu_state_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PIV_RD,
		ST_PIV_WT,
		ST_P1_CHK,
		ST_P1_RDX,
		ST_P1_RDY,
		ST_P1_WY,
		ST_MUL_GO,
		ST_MUL_WT,
		ST_DIV_GO,
		ST_DIV_WT,
		ST_P1_RDZ,
		ST_P1_WZ,
		ST_SUB_GO,
		ST_SUB_WT,
		ST_P2_CHK,
		ST_P2_RD,
		ST_P2_WT,
		ST_P2_GO,
		ST_P2_DWT,
		ST_P3_GO,
		ST_P3_WT,
		ST_OUT_RD,
		ST_OUT_EMIT
	} seq_state_t;

	// packed lower-triangle address of (r,c), either order
	function automatic logic [IDX_W-1:0] tri_idx(logic [2:0] r, logic [2:0] c);
		logic [2:0] hi;
		logic [2:0] lo;
		logic [6:0] prod;
		hi   = (r > c) ? r : c;
		lo   = (r > c) ? c : r;
		prod = {4'b0, hi} * ({4'b0, hi} + 7'd1);
		return IDX_W'(prod[6:1]) + IDX_W'(lo);
	endfunction

	function automatic logic [IDX_W-1:0] tri_total(logic [3:0] n);
		logic [7:0] prod;
		prod = {4'b0, n} * ({4'b0, n} + 8'd1);
		return IDX_W'(prod[7:1]);
	endfunction

endpackage

@@ src/smis_fpu.sv @@
// Shared iterative double-precision unit: multiply, divide and subtract with RNE rounding.
module smis_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  smis_pkg::fpu_req_t req,
	input  logic [63:0]        opa,
	input  logic [63:0]        opb,
	output logic               done,
	output logic [63:0]        result
);
	import smis_pkg::*;

	localparam logic signed [12:0] EMIN  = -13'sd1022;
	localparam logic signed [12:0] EMAX  = 13'sd1023;
	localparam logic signed [12:0] EBIAS = 13'sd1023;

	fpu_state_t fst_q, fst_d;

	fpu_op_t            op_q;
	logic               sa_q, snb_q, sign_q, effsub_q, sticky_q;
	logic signed [12:0] ea_q, eb_q, e_q;
	logic [52:0]        ma_q, mb_q;
	logic [105:0]       acc_q;
	logic [55:0]        mplr_q;
	logic [5:0]         cnt_q;
	logic [53:0]        rem_q;
	logic [55:0]        quo_q, big_q, sml_q, sig_q;
	logic [63:0]        res_q;

	logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, sx;
	logic        spec_hit;
	logic [63:0] spec_val;

	function automatic logic signed [12:0] unpack_exp(logic [10:0] be);
		return (be == 11'd0) ? EMIN : ($signed({2'b0, be}) - EBIAS);
	endfunction

	// special operands resolve at once
	always_comb begin
		a_nan    = (&opa[62:52]) & (|opa[51:0]);
		a_inf    = (&opa[62:52]) & ~(|opa[51:0]);
		a_zero   = ~(|opa[62:0]);
		b_nan    = (&opb[62:52]) & (|opb[51:0]);
		b_inf    = (&opb[62:52]) & ~(|opb[51:0]);
		b_zero   = ~(|opb[62:0]);
		sx       = opa[63] ^ opb[63];
		spec_hit = 1'b1;
		spec_val = '0;
		case (req.op)
			OP_MUL: begin
				if (a_nan)                                spec_val = opa | QUIET_BIT;
				else if (b_nan)                           spec_val = opb | QUIET_BIT;
				else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val = DEFAULT_NAN;
				else if (a_inf || b_inf)                  spec_val = {sx, 11'h7FF, 52'h0};
				else if (a_zero || b_zero)                spec_val = {sx, 63'h0};
				else                                      spec_hit = 1'b0;
			end
			OP_DIV: begin
				if (b_zero)                spec_val = (a_nan || a_zero) ? DIV_ZERO_NAN
				                                                         : {sx, 11'h7FF, 52'h0};
				else if (a_nan)            spec_val = opa | QUIET_BIT;
				else if (b_nan)            spec_val = opb | QUIET_BIT;
				else if (a_inf && b_inf)   spec_val = DEFAULT_NAN;
				else if (a_inf)            spec_val = {sx, 11'h7FF, 52'h0};
				else if (b_inf || a_zero)  spec_val = {sx, 63'h0};
				else                       spec_hit = 1'b0;
			end
			default: begin
				if (a_nan)                 spec_val = opa | QUIET_BIT;
				else if (b_nan)            spec_val = opb | QUIET_BIT;
				else if (a_inf && b_inf)   spec_val = (opa[63] == opb[63]) ? DEFAULT_NAN : opa;
				else if (a_inf)            spec_val = opa;
				else if (b_inf)            spec_val = {~opb[63], opb[62:0]};
				else if (a_zero && b_zero) spec_val = {opa[63] & ~opb[63], 63'h0};
				else if (a_zero)           spec_val = {~opb[63], opb[62:0]};
				else if (b_zero)           spec_val = opa;
				else                       spec_hit = 1'b0;
			end
		endcase
	end

	// datapath helpers
	logic [56:0]        pp;
	logic               ge;
	logic [53:0]        rem_sub;
	logic               a_big;
	logic [12:0]        ediff;
	logic [52:0]        smlm;
	logic [55:0]        sm56, sh56, lost_mask;
	logic               lost;
	logic [56:0]        sum57;
	logic               r_up;
	logic [53:0]        mant54;
	logic [52:0]        mant53;
	logic signed [12:0] e_r, be_r;
	logic [63:0]        round_val;

	always_comb begin
		pp      = ma_q * mplr_q[55:52];
		ge      = rem_q >= {1'b0, mb_q};
		rem_sub = rem_q - {1'b0, mb_q};

		a_big = (ea_q > eb_q) || ((ea_q == eb_q) && (ma_q >= mb_q));
		ediff = a_big ? 13'(ea_q - eb_q) : 13'(eb_q - ea_q);
		smlm  = a_big ? mb_q : ma_q;
		sm56  = {smlm, 3'b0};
		if (ediff >= 13'd56) begin
			sh56      = '0;
			lost_mask = '1;
		end else begin
			sh56      = sm56 >> ediff[5:0];
			lost_mask = (56'd1 << ediff[5:0]) - 56'd1;
		end
		lost = |(sm56 & lost_mask);

		sum57 = effsub_q ? ({1'b0, big_q} - {1'b0, sml_q}) : ({1'b0, big_q} + {1'b0, sml_q});

		r_up   = sig_q[2] & (sig_q[1] | sig_q[0] | sticky_q | sig_q[3]);
		mant54 = {1'b0, sig_q[55:3]} + {53'b0, r_up};
		mant53 = mant54[53] ? mant54[53:1] : mant54[52:0];
		e_r    = mant54[53] ? (e_q + 13'sd1) : e_q;
		be_r   = e_r + EBIAS;
		if (e_r > EMAX)       round_val = {sign_q, 11'h7FF, 52'h0};
		else if (!mant53[52]) round_val = {sign_q, 11'h0, mant53[51:0]};
		else                  round_val = {sign_q, be_r[10:0], mant53[51:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE;
		end else begin
			fst_q <= fst_d;
		end
	end

	always_comb begin
		fst_d = fst_q;
		done  = 1'b0;
		unique case (fst_q)
			F_IDLE: begin
				if (req.start) fst_d = spec_hit ? F_DONE : F_NORM;
			end
			F_NORM: begin
				if (ma_q[52] && mb_q[52]) begin
					case (op_q)
						OP_MUL:  fst_d = F_MUL;
						OP_DIV:  fst_d = F_DIV;
						default: fst_d = F_ALIGN;
					endcase
				end
			end
			F_MUL:    if (cnt_q == 6'd13) fst_d = F_FIN;
			F_DIV:    if (cnt_q == 6'd55) fst_d = F_FIN;
			F_FIN:    fst_d = F_LNORM;
			F_ALIGN:  fst_d = F_ADD;
			F_ADD:    fst_d = F_LNORM;
			F_LNORM: begin
				if (sig_q == '0)   fst_d = F_DONE;
				else if (sig_q[55]) fst_d = F_DENORM;
			end
			F_DENORM: if (!(e_q < EMIN)) fst_d = F_ROUND;
			F_ROUND:  fst_d = F_DONE;
			F_DONE: begin
				done  = 1'b1;
				fst_d = F_IDLE;
			end
			default:  fst_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (fst_q)
			F_IDLE: begin
				if (req.start) begin
					op_q   <= req.op;
					res_q  <= spec_val;
					ea_q   <= unpack_exp(opa[62:52]);
					eb_q   <= unpack_exp(opb[62:52]);
					ma_q   <= {|opa[62:52], opa[51:0]};
					mb_q   <= {|opb[62:52], opb[51:0]};
					sa_q   <= opa[63];
					snb_q  <= ~opb[63];
					sign_q <= opa[63] ^ opb[63];
				end
			end
			F_NORM: begin
				if (ma_q[52] && mb_q[52]) begin
					acc_q  <= '0;
					mplr_q <= {3'b0, mb_q};
					rem_q  <= {1'b0, ma_q};
					quo_q  <= '0;
					cnt_q  <= '0;
				end else begin
					// subnormal inputs: one bit a cycle
					if (!ma_q[52]) begin
						ma_q <= ma_q << 1;
						ea_q <= ea_q - 13'sd1;
					end
					if (!mb_q[52]) begin
						mb_q <= mb_q << 1;
						eb_q <= eb_q - 13'sd1;
					end
				end
			end
			F_MUL: begin
				acc_q  <= (acc_q << 4) + {49'b0, pp};
				mplr_q <= mplr_q << 4;
				cnt_q  <= cnt_q + 6'd1;
			end
			F_DIV: begin
				quo_q <= {quo_q[54:0], ge};
				rem_q <= ge ? (rem_sub << 1) : (rem_q << 1);
				cnt_q <= cnt_q + 6'd1;
			end
			F_FIN: begin
				if (op_q == OP_MUL) begin
					if (acc_q[105]) begin
						sig_q    <= acc_q[105:50];
						sticky_q <= |acc_q[49:0];
						e_q      <= ea_q + eb_q + 13'sd1;
					end else begin
						sig_q    <= acc_q[104:49];
						sticky_q <= |acc_q[48:0];
						e_q      <= ea_q + eb_q;
					end
				end else begin
					sticky_q <= |rem_q;
					if (quo_q[55]) begin
						sig_q <= quo_q;
						e_q   <= ea_q - eb_q;
					end else begin
						sig_q <= {quo_q[54:0], 1'b0};
						e_q   <= ea_q - eb_q - 13'sd1;
					end
				end
			end
			F_ALIGN: begin
				big_q    <= {(a_big ? ma_q : mb_q), 3'b0};
				sml_q    <= {sh56[55:1], sh56[0] | lost};
				e_q      <= a_big ? ea_q : eb_q;
				sign_q   <= a_big ? sa_q : snb_q;
				effsub_q <= sa_q ^ snb_q;
			end
			F_ADD: begin
				sticky_q <= 1'b0;
				if (sum57[56]) begin
					sig_q <= {sum57[56:2], sum57[1] | sum57[0]};
					e_q   <= e_q + 13'sd1;
				end else begin
					sig_q <= sum57[55:0];
				end
			end
			F_LNORM: begin
				if (sig_q == '0) begin
					res_q <= '0;
				end else if (!sig_q[55]) begin
					sig_q <= sig_q << 1;
					e_q   <= e_q - 13'sd1;
				end
			end
			F_DENORM: begin
				if (e_q < EMIN) begin
					if (sig_q == '0) begin
						e_q <= EMIN;
					end else begin
						sticky_q <= sticky_q | sig_q[0];
						sig_q    <= sig_q >> 1;
						e_q      <= e_q + 13'sd1;
					end
				end
			end
			F_ROUND: res_q <= round_val;
			default: ;
		endcase
	end

	assign result = res_q;

endmodule

@@ src/symmetric_matrix_inverse_sweep_unit.sv @@
// Top level: triangle store, sweep sequencer and result output.
//
// Entries of the lower triangle are taken one per cycle while busy is low. The
// item that completes the triangle of order n starts the sweep, and busy stays
// high until the inverse is out. The sweep runs on a single iterative
// floating-point unit that multiplies, divides and subtracts, and that takes
// longer for subnormal operands; each off-pivot update takes a multiply, a
// divide and a subtract. The inverse triangle then leaves in row-major order,
// each item first read from the store and then emitted, each on the output ports
// for exactly one cycle with strobe high; the receiver cannot stall, and
// last_entry marks the final item.
module symmetric_matrix_inverse_sweep_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] matrix_entry,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	output logic        strobe,
	output logic [63:0] inverse_entry,
	output logic [2:0]  row_index,
	output logic [2:0]  column_index,
	output logic        last_entry
);
	import smis_pkg::*;

	seq_state_t st_q, st_d;

	logic [3:0]       size_q;
	logic [IDX_W-1:0] load_cnt_q;
	logic [2:0]       k_q, i_q, j_q;
	logic [63:0]      piv_q, opa_q, opb_q, rd_q;
	logic [63:0]      store_mem [STORE_DEPTH];

	logic             strobe_q, last_q;
	logic [63:0]      out_q;
	logic [2:0]       row_q, col_q;

	logic [3:0]       n_use;
	logic [2:0]       n_last;
	logic [IDX_W-1:0] total;
	logic             accept, complete, last_pair;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	logic [63:0]      wr_data;
	fpu_req_t         req;
	logic             fpu_done;
	logic [63:0]      fpu_res;

	logic clr_k, adv_k, clr_ij, adv_pair, adv_i;
	logic ld_piv, ld_a_rd, ld_b_rd, ld_a_res, ld_b_res, ld_b_piv, ld_p3, emit;

	always_comb begin
		if (size_q == 4'd0)                  n_use = 4'd1;
		else if (size_q > 4'(MAX_ORDER))     n_use = 4'(MAX_ORDER);
		else                                 n_use = size_q;
		n_last    = 3'(n_use - 4'd1);
		total     = tri_total(n_use);
		accept    = start && !busy;
		complete  = ({1'b0, load_cnt_q} + 7'd1) >= {1'b0, total};
		last_pair = (j_q == i_q) && (i_q == n_last);
	end

	assign busy = (st_q != ST_IDLE);

	smis_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (opa_q),
		.opb    (opb_q),
		.done   (fpu_done),
		.result (fpu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			size_q     <= 4'(MAX_ORDER);
			load_cnt_q <= '0;
			strobe_q   <= 1'b0;
		end else begin
			st_q     <= st_d;
			strobe_q <= emit;
			if (cfg_we) size_q <= cfg_wdata;
			if (accept) load_cnt_q <= complete ? '0 : load_cnt_q + IDX_W'(1);
		end
	end

	always_comb begin
		st_d     = st_q;
		rd_addr  = tri_idx(i_q, j_q);
		wr_en    = 1'b0;
		wr_addr  = tri_idx(i_q, j_q);
		wr_data  = fpu_res;
		req      = '{start: 1'b0, op: OP_MUL};
		clr_k    = 1'b0;
		adv_k    = 1'b0;
		clr_ij   = 1'b0;
		adv_pair = 1'b0;
		adv_i    = 1'b0;
		ld_piv   = 1'b0;
		ld_a_rd  = 1'b0;
		ld_b_rd  = 1'b0;
		ld_a_res = 1'b0;
		ld_b_res = 1'b0;
		ld_b_piv = 1'b0;
		ld_p3    = 1'b0;
		emit     = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					wr_en   = load_cnt_q < IDX_W'(STORE_DEPTH);
					wr_addr = load_cnt_q;
					wr_data = matrix_entry;
					if (complete) begin
						clr_k = 1'b1;
						st_d  = ST_PIV_RD;
					end
				end
			end
			ST_PIV_RD: begin
				rd_addr = tri_idx(k_q, k_q);
				st_d    = ST_PIV_WT;
			end
			ST_PIV_WT: begin
				ld_piv = 1'b1;
				clr_ij = 1'b1;
				st_d   = ST_P1_CHK;
			end
			ST_P1_CHK: begin
				if ((i_q != k_q) && (j_q != k_q)) begin
					st_d = ST_P1_RDX;
				end else if (last_pair) begin
					clr_ij = 1'b1;
					st_d   = ST_P2_CHK;
				end else begin
					adv_pair = 1'b1;
				end
			end
			ST_P1_RDX: begin
				rd_addr = tri_idx(i_q, k_q);
				st_d    = ST_P1_RDY;
			end
			ST_P1_RDY: begin
				rd_addr = tri_idx(j_q, k_q);
				ld_a_rd = 1'b1;
				st_d    = ST_P1_WY;
			end
			ST_P1_WY: begin
				ld_b_rd = 1'b1;
				st_d    = ST_MUL_GO;
			end
			ST_MUL_GO: begin
				req  = '{start: 1'b1, op: OP_MUL};
				st_d = ST_MUL_WT;
			end
			ST_MUL_WT: begin
				if (fpu_done) begin
					ld_a_res = 1'b1;
					ld_b_piv = 1'b1;
					st_d     = ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				req  = '{start: 1'b1, op: OP_DIV};
				st_d = ST_DIV_WT;
			end
			ST_DIV_WT: begin
				if (fpu_done) begin
					ld_b_res = 1'b1;
					st_d     = ST_P1_RDZ;
				end
			end
			ST_P1_RDZ: begin
				rd_addr = tri_idx(i_q, j_q);
				st_d    = ST_P1_WZ;
			end
			ST_P1_WZ: begin
				ld_a_rd = 1'b1;
				st_d    = ST_SUB_GO;
			end
			ST_SUB_GO: begin
				req  = '{start: 1'b1, op: OP_SUB};
				st_d = ST_SUB_WT;
			end
			ST_SUB_WT: begin
				if (fpu_done) begin
					wr_en = 1'b1;
					if (last_pair) begin
						clr_ij = 1'b1;
						st_d   = ST_P2_CHK;
					end else begin
						adv_pair = 1'b1;
						st_d     = ST_P1_CHK;
					end
				end
			end
			ST_P2_CHK: begin
				if (i_q != k_q) begin
					st_d = ST_P2_RD;
				end else if (i_q == n_last) begin
					ld_p3 = 1'b1;
					st_d  = ST_P3_GO;
				end else begin
					adv_i = 1'b1;
				end
			end
			ST_P2_RD: begin
				rd_addr = tri_idx(i_q, k_q);
				st_d    = ST_P2_WT;
			end
			ST_P2_WT: begin
				ld_a_rd  = 1'b1;
				ld_b_piv = 1'b1;
				st_d     = ST_P2_GO;
			end
			ST_P2_GO: begin
				req  = '{start: 1'b1, op: OP_DIV};
				st_d = ST_P2_DWT;
			end
			ST_P2_DWT: begin
				if (fpu_done) begin
					wr_en   = 1'b1;
					wr_addr = tri_idx(i_q, k_q);
					if (i_q == n_last) begin
						ld_p3 = 1'b1;
						st_d  = ST_P3_GO;
					end else begin
						adv_i = 1'b1;
						st_d  = ST_P2_CHK;
					end
				end
			end
			ST_P3_GO: begin
				req  = '{start: 1'b1, op: OP_DIV};
				st_d = ST_P3_WT;
			end
			ST_P3_WT: begin
				if (fpu_done) begin
					wr_en   = 1'b1;
					wr_addr = tri_idx(k_q, k_q);
					if (k_q == n_last) begin
						clr_ij = 1'b1;
						st_d   = ST_OUT_RD;
					end else begin
						adv_k = 1'b1;
						st_d  = ST_PIV_RD;
					end
				end
			end
			ST_OUT_RD: begin
				rd_addr = tri_idx(i_q, j_q);
				st_d    = ST_OUT_EMIT;
			end
			ST_OUT_EMIT: begin
				emit = 1'b1;
				if (last_pair) begin
					st_d = ST_IDLE;
				end else begin
					adv_pair = 1'b1;
					st_d     = ST_OUT_RD;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// triangle store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) store_mem[wr_addr] <= wr_data;
		rd_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (clr_k) k_q <= '0;
		else if (adv_k) k_q <= k_q + 3'd1;
		if (clr_ij) begin
			i_q <= '0;
			j_q <= '0;
		end else if (adv_pair) begin
			if (j_q == i_q) begin
				j_q <= '0;
				i_q <= i_q + 3'd1;
			end else begin
				j_q <= j_q + 3'd1;
			end
		end else if (adv_i) begin
			i_q <= i_q + 3'd1;
		end
		if (ld_piv) piv_q <= rd_q;
		if (ld_a_rd) opa_q <= rd_q;
		else if (ld_a_res) opa_q <= fpu_res;
		else if (ld_p3) opa_q <= NEG_ONE;
		if (ld_b_rd) opb_q <= rd_q;
		else if (ld_b_res) opb_q <= fpu_res;
		else if (ld_b_piv || ld_p3) opb_q <= piv_q;
		if (emit) begin
			out_q  <= {~rd_q[63], rd_q[62:0]};
			row_q  <= i_q;
			col_q  <= j_q;
			last_q <= last_pair;
		end
	end

	assign strobe        = strobe_q;
	assign inverse_entry = out_q;
	assign row_index     = row_q;
	assign column_index  = col_q;
	assign last_entry    = strobe_q && last_q;

	a_strobe_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(st_q == ST_OUT_EMIT))
		else $error("result strobe without an emit cycle");

	a_done_while_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_done |-> (st_q == ST_MUL_WT || st_q == ST_DIV_WT || st_q == ST_SUB_WT ||
		              st_q == ST_P2_DWT || st_q == ST_P3_WT))
		else $error("arithmetic result arrived with no operation pending");

	a_complete_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && complete) |=> busy)
		else $error("completing item did not start the sweep");

	a_last_ends_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q) |-> (st_q == ST_IDLE))
		else $error("final item emitted while still busy");

endmodule

@@ verif/smis_checker.sv @@
// Checker for the sweep inverter: watches items and results, predicts the inverse and compares.
module smis_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [63:0] matrix_entry,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        strobe,
	input  logic [63:0] inverse_entry,
	input  logic [2:0]  row_index,
	input  logic [2:0]  column_index,
	input  logic        last_entry,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import smis_pkg::*;

	typedef struct {
		logic [63:0] value;
		logic [2:0]  row;
		logic [2:0]  col;
		logic        last;
	} inv_entry_t;

	inv_entry_t  inverse_q[$];
	real         tri_mem[STORE_DEPTH];
	logic [5:0]  load_cnt;
	logic [3:0]  order_reg;
	int          mismatches = 0;

	assign errors = mismatches;

	function automatic int tri_pos(int r, int c);
		int hi;
		int lo;
		hi = (r > c) ? r : c;
		lo = (r > c) ? c : r;
		return hi * (hi + 1) / 2 + lo;
	endfunction

	// division with the zero-divisor cases spelled out
	function automatic real fp_div(real a, real b);
		logic [63:0] q;
		logic [63:0] a_bits;
		logic [63:0] b_bits;
		a_bits = $realtobits(a);
		b_bits = $realtobits(b);
		if (b == 0.0) begin
			if (a != a || a == 0.0)
				return $bitstoreal(DIV_ZERO_NAN);
			q = 64'h7FF0_0000_0000_0000;
			q[63] = a_bits[63] ^ b_bits[63];
			return $bitstoreal(q);
		end
		return a / b;
	endfunction

	function automatic int order_in_use();
		if (order_reg == 0)
			return 1;
		if (order_reg > MAX_ORDER)
			return MAX_ORDER;
		return order_reg;
	endfunction

	task automatic sweep_and_queue(int n);
		real piv;
		real prod;
		int  t;
		inv_entry_t e;
		for (int k = 0; k < n; k++) begin
			piv = tri_mem[tri_pos(k, k)];
			for (int i = 0; i < n; i++)
				for (int j = 0; j <= i; j++)
					if (i != k && j != k) begin
						prod = tri_mem[tri_pos(i, k)] * tri_mem[tri_pos(j, k)];
						tri_mem[tri_pos(i, j)] = tri_mem[tri_pos(i, j)] - fp_div(prod, piv);
					end
			for (int i = 0; i < n; i++)
				if (i != k) begin
					t = tri_pos(i, k);
					tri_mem[t] = fp_div(tri_mem[t], piv);
				end
			tri_mem[tri_pos(k, k)] = fp_div($bitstoreal(NEG_ONE), piv);
		end
		for (int i = 0; i < n; i++)
			for (int j = 0; j <= i; j++) begin
				t = tri_pos(i, j);
				tri_mem[t] = $bitstoreal($realtobits(tri_mem[t]) ^ {1'b1, 63'b0});
				e.value = $realtobits(tri_mem[t]);
				e.row   = i[2:0];
				e.col   = j[2:0];
				e.last  = (i == n - 1) && (j == i);
				inverse_q.push_back(e);
			end
	endtask

	task automatic load_entry(logic [63:0] x);
		int n;
		int slot;
		n = order_in_use();
		slot = load_cnt;
		if (slot < STORE_DEPTH)
			tri_mem[slot] = $bitstoreal(x);
		load_cnt = load_cnt + 6'd1;
		if (slot + 1 >= n * (n + 1) / 2) begin
			load_cnt = '0;
			sweep_and_queue(n);
		end
	endtask

	task automatic check_result();
		inv_entry_t e;
		if (inverse_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: %h r%0d c%0d last%0b",
					inverse_entry, row_index, column_index, last_entry);
			return;
		end
		e = inverse_q.pop_front();
		if (e.value !== inverse_entry || e.row !== row_index || e.col !== column_index
				|| e.last !== last_entry) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp %h r%0d c%0d last%0b, got %h r%0d c%0d last%0b",
					e.value, e.row, e.col, e.last,
					inverse_entry, row_index, column_index, last_entry);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_reg = 4'd8;
			load_cnt  = '0;
			inverse_q.delete();
		end else begin
			if (strobe)
				check_result();
			// an item taken at this edge still sees the old order
			if (start && !busy)
				load_entry(matrix_entry);
			if (cfg_we)
				order_reg = cfg_wdata;
		end
		pending = inverse_q.size();
	end

endmodule

@@ verif/tb_symmetric_matrix_inverse_sweep_unit.sv @@
// Testbench top for the sweep inverter: clock, reset, stimulus and verdict.
module tb_symmetric_matrix_inverse_sweep_unit;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] matrix_entry;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;
	logic        strobe;
	logic [63:0] inverse_entry;
	logic [2:0]  row_index;
	logic [2:0]  column_index;
	logic        last_entry;
	int          errors;
	int          pending;
	int          gap_pct;
	int          sent;

	symmetric_matrix_inverse_sweep_unit dut (
		.clk, .arst_n, .start, .busy, .matrix_entry, .cfg_we, .cfg_wdata,
		.strobe, .inverse_entry, .row_index, .column_index, .last_entry
	);

	smis_checker chk (
		.clk, .arst_n, .start, .busy, .matrix_entry, .cfg_we, .cfg_wdata,
		.strobe, .inverse_entry, .row_index, .column_index, .last_entry,
		.errors, .pending
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_symmetric_matrix_inverse_sweep_unit: FAIL");
		$finish;
	end

	task automatic send_entry(logic [63:0] x);
		if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		start        <= 1'b1;
		matrix_entry <= x;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	// wait until every queued inverse entry is out, then let the unit settle
	task automatic drain();
		start <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_order(logic [3:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// raw bit pattern with infinities and NaNs folded back to finite values
	function automatic logic [63:0] raw_finite();
		logic [63:0] x;
		x = {$urandom, $urandom};
		if (x[62:52] == 11'h7FF)
			x[52] = 1'b0;
		return x;
	endfunction

	function automatic logic [63:0] spd_entry(int r, int c);
		if (r == c)
			return $realtobits(real'($urandom_range(2000, 200)) / 100.0);
		return $realtobits((real'($urandom_range(2000, 0)) - 1000.0) / 1000.0);
	endfunction

	task automatic send_matrix(int n, bit raw);
		for (int r = 0; r < n; r++)
			for (int c = 0; c <= r; c++)
				send_entry(raw ? raw_finite() : spd_entry(r, c));
	endtask

	initial begin
		int n;
		arst_n       = 1'b0;
		start        = 1'b0;
		matrix_entry = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		gap_pct      = 0;
		sent         = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// order 8 out of reset
		send_matrix(8, 0);
		// size 0 acts as 1: zero and signed-zero pivots, extremes
		set_order(4'd0);
		send_entry(64'h0000_0000_0000_0000);
		send_entry(64'h8000_0000_0000_0000);
		send_entry(64'h7FEF_FFFF_FFFF_FFFF);
		send_entry(64'hFFEF_FFFF_FFFF_FFFF);
		send_entry(64'h0000_0000_0000_0001);
		send_entry(64'hBFF0_0000_0000_0000);
		set_order(4'd1);
		send_entry(64'h3FF0_0000_0000_0000);
		// zero second pivot
		set_order(4'd2);
		send_entry(64'h4000_0000_0000_0000);
		send_entry(64'h4000_0000_0000_0000);
		send_entry(64'h4000_0000_0000_0000);
		send_matrix(2, 1);
		// size shrinks mid-load: completes on the next item
		set_order(4'd4);
		send_matrix(2, 0);
		set_order(4'd2);
		send_entry(spd_entry(1, 1));
		// above the maximum acts as 8
		set_order(4'd15);
		send_matrix(8, 0);
		set_order(4'd9);
		send_matrix(1, 0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: gap_pct = 0;
				1: gap_pct = 65;
				2: gap_pct = 0;
				default: gap_pct = 19;
			endcase
			while (sent < 80 + 95 * (phase + 1)) begin
				n = ($urandom_range(19, 0) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
				set_order(n[3:0]);
				send_matrix(n, n <= 2 && $urandom_range(4, 0) == 0);
			end
			drain();
		end

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_symmetric_matrix_inverse_sweep_unit: PASS");
		else
			$display("tb_symmetric_matrix_inverse_sweep_unit: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
src/smis_pkg.sv
src/smis_fpu.sv
src/symmetric_matrix_inverse_sweep_unit.sv
verif/smis_checker.sv
verif/tb_symmetric_matrix_inverse_sweep_unit.sv
